[design/u8san_pkg.sv]
package u8san_pkg;

    localparam int RUN_MAX = 4;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] LEAD_SURR  = 8'hED;
    localparam logic [7:0] SECOND_A0  = 8'hA0;
    localparam logic [7:0] SECOND_90  = 8'h90;
    localparam logic [7:0] QMARK      = 8'h3F;

    // sequence length codes
    localparam logic [2:0] LEN_INVALID = 3'd0;
    localparam logic [2:0] LEN_ASCII   = 3'd1;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_THREE   = 3'd3;
    localparam logic [2:0] LEN_FOUR    = 3'd4;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t [RUN_MAX-1:0] bytes;
        logic [2:0]          count;
        logic                eos;
    } run_t;

    function automatic logic [2:0] lead_length(input byte_t b);
        logic [2:0] len;
        begin
            len = LEN_INVALID;
            if (b[7] == 1'b0)
                len = LEN_ASCII;
            else if (b >= LEAD2_LO && b <= LEAD2_HI)
                len = LEN_TWO;
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
                len = LEN_THREE;
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
                len = LEN_FOUR;
            return len;
        end
    endfunction

endpackage

[design/u8san_in_if.sv]
interface u8san_in_if;
    import u8san_pkg::*;

    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

[design/u8san_out_if.sv]
interface u8san_out_if;
    import u8san_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  run_last;
    logic  string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface

[design/u8san_judge.sv]
module u8san_judge
    import u8san_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  byte_t in_byte,
    input  logic  end_of_string,
    output run_t  run
);

    byte_t      lead_reg, lead_next;
    byte_t      tail_reg [2];
    byte_t      tail_next [2];
    logic [1:0] held_reg, held_next;
    logic [2:0] seq_len_reg, seq_len_next;

    logic       cont_ok;
    logic       fresh;
    logic [1:0] pos;
    logic [2:0] len;

    always_comb
    begin
        cont_ok = ((in_byte & CONT_MASK) == CONT_TAG);
        if (held_reg == 2'd1)
        begin
            if (lead_reg == LEAD3_LO && in_byte < SECOND_A0)
                cont_ok = 1'b0;
            if (lead_reg == LEAD_SURR && in_byte >= SECOND_A0)
                cont_ok = 1'b0;
            if (lead_reg == LEAD4_LO && in_byte < SECOND_90)
                cont_ok = 1'b0;
            if (lead_reg == LEAD4_HI && in_byte >= SECOND_90)
                cont_ok = 1'b0;
        end
    end

    always_comb
    begin
        run          = '0;
        run.eos      = end_of_string;
        lead_next    = lead_reg;
        tail_next    = tail_reg;
        held_next    = held_reg;
        seq_len_next = seq_len_reg;
        fresh        = 1'b1;
        pos          = 2'd0;
        len          = lead_length(in_byte);

        if (held_reg != 2'd0)
        begin
            if (cont_ok)
            begin
                fresh = 1'b0;
                if (({1'b0, held_reg} + 3'd1 >= seq_len_reg) || held_reg == 2'd3)
                begin
                    // sequence complete: flush lead, tails, then this byte
                    run.bytes[0] = lead_reg;
                    for (int i = 1; i < RUN_MAX; i++)
                    begin
                        if (2'(i) < held_reg)
                            run.bytes[i] = tail_reg[1'(i - 1)];
                        else if (2'(i) == held_reg)
                            run.bytes[i] = in_byte;
                    end
                    run.count    = {1'b0, held_reg} + 3'd1;
                    held_next    = 2'd0;
                    seq_len_next = 3'd0;
                end
                else
                begin
                    tail_next[held_reg[0] ^ 1'b1] = in_byte;
                    held_next = held_reg + 2'd1;
                    if (end_of_string)
                    begin
                        for (int i = 0; i < RUN_MAX; i++)
                        begin
                            if (2'(i) <= held_reg)
                                run.bytes[i] = QMARK;
                        end
                        run.count    = {1'b0, held_reg} + 3'd1;
                        held_next    = 2'd0;
                        seq_len_next = 3'd0;
                    end
                end
            end
            else
            begin
                // broken sequence: replace held bytes, re-judge this byte
                for (int i = 0; i < RUN_MAX - 1; i++)
                begin
                    if (2'(i) < held_reg)
                        run.bytes[i] = QMARK;
                end
                pos          = held_reg;
                held_next    = 2'd0;
                seq_len_next = 3'd0;
            end
        end

        if (fresh)
        begin
            run.count = {1'b0, pos};
            case (len)
                LEN_ASCII:
                begin
                    run.bytes[pos] = in_byte;
                    run.count      = {1'b0, pos} + 3'd1;
                end
                LEN_TWO, LEN_THREE, LEN_FOUR:
                begin
                    if (end_of_string)
                    begin
                        run.bytes[pos] = QMARK;
                        run.count      = {1'b0, pos} + 3'd1;
                    end
                    else
                    begin
                        lead_next    = in_byte;
                        held_next    = 2'd1;
                        seq_len_next = len;
                    end
                end
                default:
                begin
                    run.bytes[pos] = QMARK;
                    run.count      = {1'b0, pos} + 3'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= 2'd0;
            seq_len_reg <= 3'd0;
        end
        else if (accept)
        begin
            held_reg    <= held_next;
            seq_len_reg <= seq_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lead_reg    <= lead_next;
            tail_reg[0] <= tail_next[0];
            tail_reg[1] <= tail_next[1];
        end
    end

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != 2'd0 |-> (seq_len_reg >= LEN_TWO && seq_len_reg <= LEN_FOUR))
        else $error("held sequence has bad length");

    a_held_short: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != 2'd0 |-> {1'b0, held_reg} < seq_len_reg)
        else $error("held count reached sequence length");

    a_idle_len: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg == 2'd0 |-> seq_len_reg == 3'd0)
        else $error("length left over with nothing held");

endmodule

[design/u8san_drain.sv]
module u8san_drain
    import u8san_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_req,
    input  run_t                run,
    output logic                run_ready,
    u8san_out_if.source         out_ch
);

    byte_t      buf_reg [RUN_MAX];
    logic       eos_reg;
    logic [2:0] rem_reg, rem_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_fire;
    logic       load;

    assign out_fire  = out_ch.valid && out_ch.ready;
    assign load      = load_req && (run.count != 3'd0);
    assign run_ready = (rem_reg == 3'd0) || (rem_reg == 3'd1 && out_ch.ready);

    assign out_ch.valid      = (rem_reg != 3'd0);
    assign out_ch.out_byte   = buf_reg[idx_reg];
    assign out_ch.run_last   = (rem_reg == 3'd1);
    assign out_ch.string_end = (rem_reg == 3'd1) && eos_reg;

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (out_fire)
        begin
            rem_next = rem_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
        if (load)
        begin
            rem_next = run.count;
            idx_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < RUN_MAX; i++)
                buf_reg[i] <= run.bytes[i];
            eos_reg <= run.eos;
        end
    end

    a_rem_max: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'(RUN_MAX))
        else $error("run count out of range");

    a_idx_fit: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != 3'd0 |-> ({2'b00, idx_reg} + {1'b0, rem_reg}) <= 4'(RUN_MAX))
        else $error("run read past buffer end");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (rem_reg == $past(run.count) && idx_reg == 2'd0))
        else $error("run not loaded");

endmodule

[design/utf8_sanitizer_top.sv]
// The first result of a byte is registered and presented the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and the output is
// ready; a byte that yields a run of results (up to 4, one per cycle from the result buffer
// while the output is ready) holds off the input until the last result of the run is taken.
// Reset: asynchronous, clears the held sequence and empties the result buffer.
module utf8_sanitizer_top
    import u8san_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    u8san_in_if.sink     in_ch,
    u8san_out_if.source  out_ch
);

    run_t run;
    logic run_ready;
    logic accept;

    assign in_ch.ready = run_ready;
    assign accept      = in_ch.valid && run_ready;

    u8san_judge u_judge (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_ch.in_byte),
        .end_of_string (in_ch.end_of_string),
        .run           (run)
    );

    u8san_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_req  (accept),
        .run       (run),
        .run_ready (run_ready),
        .out_ch    (out_ch)
    );

endmodule
